/* hw/rtl/token_bucket_queue_depth_throttle_assert.svh */
// assertion macros shared by the throttle checker
// no dependencies; included by the checker file only
`ifndef TOKEN_BUCKET_QUEUE_DEPTH_THROTTLE_ASSERT_SVH
`define TOKEN_BUCKET_QUEUE_DEPTH_THROTTLE_ASSERT_SVH

// same-cycle implication
`define TBQDT_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBQDT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tbqdt_pkg.sv */
// package for the token bucket queue depth throttle
// constants, widths and codes; no dependencies
package tbqdt_pkg;

  localparam int WINDOW_LEN = 5;
  localparam int BURST_MULT = 2;

  localparam int BUDGET_W   = 36;
  localparam int REQ_W      = 29;
  localparam int DEPTH_W    = 7;
  localparam int WIDX_W     = 6;
  localparam int ACC_W      = 40;
  localparam int LEVEL_W    = 37;
  localparam int BUCKET_W   = BUDGET_W + ((BURST_MULT > 1) ? $clog2(BURST_MULT) : 0);
  localparam int SUM_W      = ACC_W + ((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0);
  localparam int CMP_W      = SUM_W + 10;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

  // deficit: 100*S < 97*LEN*B, surplus: 1000*S >= 995*LEN*B
  localparam int DEF_SCALE  = 100;
  localparam int SUR_SCALE  = 1000;
  localparam int DEF_MULT   = 97 * WINDOW_LEN;
  localparam int SUR_MULT   = 995 * WINDOW_LEN;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(64);
  localparam logic [DEPTH_W-1:0] MIN_DEPTH   = DEPTH_W'(2);
  localparam logic [1:0]         DEF_COUNT_MAX = 2'd2;
  localparam logic [4:0]         SUR_COUNT_MAX = 5'd20;

  localparam logic [REQ_W-1:0]   REQ_BYTES_RST = REQ_W'(1048576);
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = DEPTH_W'(8);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ISSUE = 2'd1,
    CMD_DONE  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_GRANT    = 2'd0,
    ST_PARKED   = 2'd1,
    ST_NO_TOKEN = 2'd2,
    ST_ACK      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BUDGET      = 2'd0,
    REG_REQ_BYTES   = 2'd1,
    REG_MAX_DEPTH   = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

endpackage

/* hw/rtl/token_bucket_queue_depth_throttle.sv */
// token bucket read-request throttle with closed-loop queue depth control
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while the result is not stalled; a single input register feeds one pass of
//   logic that updates the state and loads the result register
// reset (rst, synchronous): state, window and counts cleared, registers to defaults
// depends on tbqdt_pkg
module token_bucket_queue_depth_throttle
  import tbqdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic [1:0]           cmd,
  input  logic [WIDX_W-1:0]    worker_index,
  input  logic [REQ_W-1:0]     bytes_read,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [1:0]           status,
  output logic [DEPTH_W-1:0]   active_depth,
  output logic [ACC_W-1:0]     tick_bytes,
  output logic [LEVEL_W-1:0]   token_level,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int NEXT_OLD = (WINDOW_LEN > 1) ? WINDOW_LEN - 2 : 0;

  // configuration registers
  logic [BUDGET_W-1:0] budget_bytes;
  logic [REQ_W-1:0]    request_bytes;
  logic [DEPTH_W-1:0]  max_queue_depth;
  // thresholds scaled from the budget at write time
  logic [CMP_W-1:0]    thr_def;
  logic [CMP_W-1:0]    thr_sur;

  // input register
  logic                in_vld;
  cmd_t                in_cmd;
  logic [WIDX_W-1:0]   in_widx;
  logic [REQ_W-1:0]    in_bytes;

  // throttle state
  logic [BUCKET_W-1:0] bucket;
  logic [DEPTH_W-1:0]  depth_now;
  logic [ACC_W-1:0]    tick_accum;
  logic [ACC_W-1:0]    window [WINDOW_LEN];   // shift line, oldest at the end
  logic [SUM_W-1:0]    sum_excl;               // window sum less the oldest entry
  logic [FILL_W-1:0]   window_fill;
  logic [1:0]          deficit_count;
  logic [4:0]          surplus_count;

  // next values
  logic [BUCKET_W-1:0] bucket_next;
  logic [DEPTH_W-1:0]  depth_now_next;
  logic [ACC_W-1:0]    tick_accum_next;
  logic [SUM_W-1:0]    sum_excl_next;
  logic [FILL_W-1:0]   window_fill_next;
  logic [1:0]          deficit_count_next;
  logic [4:0]          surplus_count_next;
  logic                window_push;
  logic [ACC_W-1:0]    closed;
  status_t             status_next;

  // working signals
  logic                advance;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic [DEPTH_W-1:0]  eff_max;
  logic                unlimited;
  logic [BUCKET_W:0]   refill_sum;
  logic [BUCKET_W-1:0] bucket_cap;
  logic [ACC_W:0]      accum_sum;
  logic [SUM_W-1:0]    sum_new;
  logic [CMP_W-1:0]    sum_x_def;
  logic [CMP_W-1:0]    sum_x_sur;
  logic                full;
  logic                is_deficit;
  logic                is_surplus;
  logic [1:0]          dc_inc;
  logic [4:0]          sc_inc;
  logic [ACC_W-1:0]    next_oldest;

  // pipeline control: the input register moves on whenever the result slot frees
  assign advance   = !result_valid || result_ready;
  assign cmd_ready = !in_vld || advance;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);

  always_comb begin
    case (cfg_idx)
      REG_BUDGET:      prdata = 64'(budget_bytes);
      REG_REQ_BYTES:   prdata = 64'(request_bytes);
      REG_MAX_DEPTH:   prdata = 64'(max_queue_depth);
      default:         prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_bytes    <= '0;
      request_bytes   <= REQ_BYTES_RST;
      max_queue_depth <= MAX_DEPTH_RST;
      thr_def         <= '0;
      thr_sur         <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BUDGET: begin
          budget_bytes <= pwdata[BUDGET_W-1:0];
          // constant multiplies, so the tick path only scales the sum
          thr_def     <= CMP_W'(pwdata[BUDGET_W-1:0]) * CMP_W'(DEF_MULT);
          thr_sur     <= CMP_W'(pwdata[BUDGET_W-1:0]) * CMP_W'(SUR_MULT);
        end
        REG_REQ_BYTES:   request_bytes   <= pwdata[REQ_W-1:0];
        REG_MAX_DEPTH:   max_queue_depth <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // shared terms
  assign eff_max     = (max_queue_depth > DEPTH_LIMIT) ? DEPTH_LIMIT : max_queue_depth;
  assign unlimited   = (budget_bytes == '0);
  assign refill_sum  = (BUCKET_W + 1)'(bucket) + (BUCKET_W + 1)'(budget_bytes);
  assign bucket_cap  = BUCKET_W'(budget_bytes) * BUCKET_W'(BURST_MULT);
  assign accum_sum   = (ACC_W + 1)'(tick_accum) + (ACC_W + 1)'(in_bytes);
  // window sum once the open tick is pushed and the oldest entry drops out
  assign sum_new     = sum_excl + SUM_W'(tick_accum);
  assign sum_x_def   = CMP_W'(sum_new) * CMP_W'(DEF_SCALE);
  assign sum_x_sur   = CMP_W'(sum_new) * CMP_W'(SUR_SCALE);
  assign window_fill_next = (window_fill < FILL_W'(WINDOW_LEN)) ? window_fill + 1'b1
                                                                : window_fill;
  assign full        = (window_fill_next == FILL_W'(WINDOW_LEN));
  assign is_deficit  = full && (sum_x_def < thr_def);
  assign is_surplus  = full && !is_deficit && (sum_x_sur >= thr_sur);
  assign dc_inc      = (deficit_count < DEF_COUNT_MAX) ? deficit_count + 1'b1 : deficit_count;
  assign sc_inc      = (surplus_count < SUR_COUNT_MAX) ? surplus_count + 1'b1 : surplus_count;
  // entry that becomes the oldest after the push
  assign next_oldest = (WINDOW_LEN > 1) ? window[NEXT_OLD] : tick_accum;

  // one pass over the item in the input register
  always_comb begin
    bucket_next        = bucket;
    depth_now_next     = depth_now;
    tick_accum_next    = tick_accum;
    sum_excl_next      = sum_excl;
    deficit_count_next = deficit_count;
    surplus_count_next = surplus_count;
    window_push        = 1'b0;
    closed             = '0;
    status_next        = ST_ACK;

    case (in_cmd)
      CMD_START: begin
        bucket_next = BUCKET_W'(budget_bytes);
        if (!unlimited) begin
          depth_now_next = (eff_max < MIN_DEPTH) ? eff_max : MIN_DEPTH;
        end else begin
          depth_now_next = eff_max;
        end
        tick_accum_next    = '0;
        sum_excl_next      = '0;
        deficit_count_next = '0;
        surplus_count_next = '0;
      end
      CMD_ISSUE: begin
        if (DEPTH_W'(in_widx) >= depth_now) begin
          status_next = ST_PARKED;
        end else if (unlimited) begin
          status_next = ST_GRANT;
        end else if (bucket >= BUCKET_W'(request_bytes)) begin
          bucket_next = bucket - BUCKET_W'(request_bytes);
          status_next = ST_GRANT;
        end else begin
          status_next = ST_NO_TOKEN;
        end
      end
      CMD_DONE: begin
        // saturating byte count
        tick_accum_next = accum_sum[ACC_W] ? '1 : accum_sum[ACC_W-1:0];
      end
      CMD_TICK: begin
        closed          = tick_accum;
        tick_accum_next = '0;
        if (!unlimited) begin
          bucket_next   = (refill_sum > (BUCKET_W + 1)'(bucket_cap)) ? bucket_cap
                                                                     : refill_sum[BUCKET_W-1:0];
          window_push   = 1'b1;
          sum_excl_next = sum_new - SUM_W'(next_oldest);
          if (is_deficit) begin
            deficit_count_next = dc_inc;
            if (dc_inc >= DEF_COUNT_MAX && depth_now < eff_max) begin
              depth_now_next     = depth_now + 1'b1;
              deficit_count_next = '0;
            end
            surplus_count_next = '0;
          end else if (is_surplus) begin
            surplus_count_next = sc_inc;
            if (sc_inc >= SUR_COUNT_MAX && depth_now > MIN_DEPTH) begin
              depth_now_next     = depth_now - 1'b1;
              surplus_count_next = '0;
            end
            deficit_count_next = '0;
          end else begin
            deficit_count_next = '0;
            surplus_count_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (cmd_ready) begin
      in_vld <= cmd_valid;
    end
    if (cmd_valid && cmd_ready) begin
      in_cmd   <= cmd_t'(cmd);
      in_widx  <= worker_index;
      in_bytes <= bytes_read;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      bucket        <= '0;
      depth_now     <= '0;
      tick_accum    <= '0;
      sum_excl      <= '0;
      window_fill   <= '0;
      deficit_count <= '0;
      surplus_count <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (advance) begin
      result_valid <= in_vld;
      if (in_vld) begin
        bucket        <= bucket_next;
        depth_now     <= depth_now_next;
        tick_accum    <= tick_accum_next;
        sum_excl      <= sum_excl_next;
        deficit_count <= deficit_count_next;
        surplus_count <= surplus_count_next;
        // a start empties the window
        if (in_cmd == CMD_START) begin
          window_fill <= '0;
          for (int i = 0; i < WINDOW_LEN; i++) begin
            window[i] <= '0;
          end
        end else if (window_push) begin
          window_fill <= window_fill_next;
          window[0]   <= closed;
          for (int i = 1; i < WINDOW_LEN; i++) begin
            window[i] <= window[i-1];
          end
        end
        status       <= status_next;
        active_depth <= depth_now_next;
        tick_bytes   <= closed;
        token_level  <= LEVEL_W'(bucket_next);
      end
    end
  end

endmodule

/* hw/rtl/tbqdt_checker.sv */
// port-level checks for the token bucket queue depth throttle, with its bind
// depends on tbqdt_pkg and token_bucket_queue_depth_throttle_assert.svh
`include "token_bucket_queue_depth_throttle_assert.svh"
module tbqdt_checker
  import tbqdt_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [1:0]           status,
  input logic [DEPTH_W-1:0]   active_depth,
  input logic [ACC_W-1:0]     tick_bytes,
  input logic [LEVEL_W-1:0]   token_level
);

  // a stalled result keeps its item
  `TBQDT_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(status) && $stable(token_level) && $stable(tick_bytes), "result changed while stalled")

  // depth never passes the worker limit
  `TBQDT_ASSERT_SAME(a_depth_limit, clk, rst, result_valid, active_depth <= DEPTH_LIMIT, "active depth above limit")

  // closed tick bytes only come with an acknowledge
  `TBQDT_ASSERT_SAME(a_tick_bytes_ack, clk, rst, result_valid && tick_bytes != '0, status == ST_ACK, "tick bytes on a request result")

  // reset empties the result slot
  `TBQDT_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, !result_valid, "result valid after reset")

endmodule

bind token_bucket_queue_depth_throttle tbqdt_checker u_tbqdt_checker (.*);

/* tb/sv/token_bucket_queue_depth_throttle_test.sv */
// self-checking bench for the token bucket queue depth throttle
// a bit-exact predictor in a small scoreboard class checks every result
// depends on tbqdt_pkg and token_bucket_queue_depth_throttle
module token_bucket_queue_depth_throttle_test
  import tbqdt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned BYTES_MAX = (1 << REQ_W) - 1;
  localparam longint unsigned TICK_BYTES_MAX = (64'd1 << ACC_W) - 1;
  localparam longint unsigned BUDGET_MAX = (64'd1 << BUDGET_W) - 1;
  // controller thresholds, as ratios of the window budget
  localparam longint unsigned DEFICIT_NUM = 97;
  localparam longint unsigned DEFICIT_DEN = 100;
  localparam longint unsigned SURPLUS_NUM = 995;
  localparam longint unsigned SURPLUS_DEN = 1000;

  typedef struct packed {
    status_t              status;
    logic [DEPTH_W-1:0]   depth;
    logic [ACC_W-1:0]     tick_bytes;
    logic [LEVEL_W-1:0]   level;
  } throttle_result_t;

  // per-tick completion load shapes that steer the depth controller
  typedef enum logic [1:0] {
    LOAD_LOW,
    LOAD_HEAVY,
    LOAD_EDGE,
    LOAD_WILD
  } load_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_t;

  // predictor of the throttle plus the queue of results still owed
  class throttle_scoreboard;
    longint unsigned budget;
    longint unsigned req_bytes;
    longint unsigned max_depth;
    longint unsigned bucket;
    longint unsigned depth;
    longint unsigned accum;
    longint unsigned win [WINDOW_LEN];
    longint unsigned win_sum;
    int unsigned win_pos;
    int unsigned win_fill;
    int unsigned deficit;
    int unsigned surplus;
    throttle_result_t owed [$];
    int unsigned errors;

    function new();
      budget = 0;
      req_bytes = REQ_BYTES_RST;
      max_depth = MAX_DEPTH_RST;
      bucket = 0;
      depth = 0;
      clear_run();
      errors = 0;
    endfunction

    function void clear_run();
      accum = 0;
      foreach (win[i]) win[i] = 0;
      win_sum = 0;
      win_pos = 0;
      win_fill = 0;
      deficit = 0;
      surplus = 0;
    endfunction

    function longint unsigned depth_cap();
      return (max_depth > DEPTH_LIMIT) ? longint'(DEPTH_LIMIT) : max_depth;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] value);
      case (idx)
        REG_BUDGET:      budget = value[BUDGET_W-1:0];
        REG_REQ_BYTES:   req_bytes = value[REQ_W-1:0];
        REG_MAX_DEPTH:   max_depth = value[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    // push the closed tick into the window and run the depth controller
    function void close_window(longint unsigned closed);
      int unsigned slot;
      longint unsigned goal;
      bit full;
      slot = (win_pos < WINDOW_LEN) ? win_pos : 0;
      win_sum = win_sum - win[slot] + closed;
      win[slot] = closed;
      win_pos = (slot + 1) % WINDOW_LEN;
      if (win_fill < WINDOW_LEN) win_fill++;
      full = (win_fill == WINDOW_LEN);
      goal = WINDOW_LEN * budget;
      if (full && win_sum * DEFICIT_DEN < goal * DEFICIT_NUM) begin
        if (deficit < DEF_COUNT_MAX) deficit++;
        if (deficit >= DEF_COUNT_MAX && depth < depth_cap()) begin
          depth++;
          deficit = 0;
        end
        surplus = 0;
      end else if (full && win_sum * SURPLUS_DEN >= goal * SURPLUS_NUM) begin
        if (surplus < SUR_COUNT_MAX) surplus++;
        if (surplus >= SUR_COUNT_MAX && depth > MIN_DEPTH) begin
          depth--;
          surplus = 0;
        end
        deficit = 0;
      end else begin
        deficit = 0;
        surplus = 0;
      end
    endfunction

    function void note_item(cmd_t c, logic [WIDX_W-1:0] w, logic [REQ_W-1:0] b);
      throttle_result_t r;
      longint unsigned grown;
      longint unsigned m;
      r.status = ST_ACK;
      r.tick_bytes = '0;
      case (c)
        CMD_START: begin
          m = depth_cap();
          bucket = budget;
          if (budget != 0) depth = (m < MIN_DEPTH) ? m : longint'(MIN_DEPTH);
          else depth = m;
          clear_run();
        end
        CMD_ISSUE: begin
          if (w >= depth) r.status = ST_PARKED;
          else if (budget == 0) r.status = ST_GRANT;
          else if (bucket >= req_bytes) begin
            bucket -= req_bytes;
            r.status = ST_GRANT;
          end else r.status = ST_NO_TOKEN;
        end
        CMD_DONE: begin
          grown = accum + b;
          accum = (grown > TICK_BYTES_MAX) ? TICK_BYTES_MAX : grown;
        end
        default: begin
          if (budget != 0) begin
            grown = bucket + budget;
            bucket = (grown > BURST_MULT * budget) ? BURST_MULT * budget : grown;
          end
          r.tick_bytes = accum;
          grown = accum;
          accum = 0;
          if (budget != 0) close_window(grown);
        end
      endcase
      r.depth = depth;
      r.level = bucket[LEVEL_W-1:0];
      owed.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [DEPTH_W-1:0] d,
                               logic [ACC_W-1:0] tb, logic [LEVEL_W-1:0] lv);
      throttle_result_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with none owed: status %0d depth %0d tick %0d level %0d",
                 $time, st, d, tb, lv);
        return;
      end
      e = owed.pop_front();
      if (st !== e.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, e.status, st);
      end
      if (d !== e.depth) begin
        errors++;
        $display("%0t: active_depth expected %0d got %0d", $time, e.depth, d);
      end
      if (tb !== e.tick_bytes) begin
        errors++;
        $display("%0t: tick_bytes expected %0d got %0d", $time, e.tick_bytes, tb);
      end
      if (lv !== e.level) begin
        errors++;
        $display("%0t: token_level expected %0d got %0d", $time, e.level, lv);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  logic [1:0]           cmd = CMD_START;
  logic [WIDX_W-1:0]    worker_index = '0;
  logic [REQ_W-1:0]     bytes_read = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [1:0]           status;
  logic [DEPTH_W-1:0]   active_depth;
  logic [ACC_W-1:0]     tick_bytes;
  logic [LEVEL_W-1:0]   token_level;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [4:0]           paddr = '0;
  logic [63:0]          pwdata = '0;
  logic [63:0]          prdata;
  logic                 pready;

  throttle_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned cfg_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  load_t load_mode = LOAD_LOW;
  int unsigned seg_left = 0;

  token_bucket_queue_depth_throttle u_top (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .worker_index (worker_index),
    .bytes_read   (bytes_read),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .active_depth (active_depth),
    .tick_bytes   (tick_bytes),
    .token_level  (token_level),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("token_bucket_queue_depth_throttle: mismatch");
      $finish;
    end
  end

  // receiver: random back-pressure at the rate of the current phase
  always @(posedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: both handshakes sampled at the edge, so values are pre-update
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready)
        sb.note_item(cmd_t'(cmd), worker_index, bytes_read);
      if (result_valid && result_ready)
        sb.check_result(status, active_depth, tick_bytes, token_level);
    end
  end

  // offer one item, with random gaps first; returns at the accepting edge
  task automatic send_item(input cmd_t c, input logic [WIDX_W-1:0] w,
                           input logic [REQ_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    worker_index <= w;
    bytes_read <= b;
    do @(posedge clk); while (!cmd_ready);
    items_sent++;
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle();
    cmd_valid <= 1'b0;
    // wait for a clock edge first so the monitor has noted the last accepted item
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a read-back of the same register
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    logic [63:0] mask;
    logic [63:0] got;
    case (idx)
      REG_BUDGET:      mask = (64'd1 << BUDGET_W) - 1;
      REG_REQ_BYTES:   mask = (64'd1 << REQ_W) - 1;
      default:         mask = (64'd1 << DEPTH_W) - 1;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    // turn straight into the setup phase of the read-back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (value & mask)) begin
      cfg_errors++;
      $display("%0t: register %s read expected %0d got %0d", $time, idx.name(),
               value & mask, got & mask);
    end
  endtask

  // one well-formed tick: up to three requests, completions shaped by the load mode, a tick
  task automatic tick_period();
    longint unsigned total;
    longint unsigned part;
    int unsigned n_req;
    int unsigned n_done;
    int unsigned top;
    if (seg_left == 0) begin
      load_mode = load_t'($urandom_range(3));
      seg_left = $urandom_range(8, 30);
    end
    seg_left--;
    case (load_mode)
      LOAD_LOW:   total = sb.budget / 2;
      LOAD_HEAVY: total = sb.budget + sb.budget / 16 + $urandom_range(64);
      LOAD_EDGE:  total = sb.budget - sb.budget / 50;
      default:    total = (longint'($urandom_range(200)) * sb.budget) / 100;
    endcase
    n_req = $urandom_range(3);
    n_done = $urandom_range(1, 3);
    if (total > n_done * BYTES_MAX) total = n_done * BYTES_MAX;
    // worker index up to the active depth itself, so parking shows up too
    repeat (n_req) begin
      top = (sb.depth > 63) ? 63 : sb.depth;
      send_item(CMD_ISSUE, $urandom_range(top), $urandom_range(BYTES_MAX));
    end
    for (int unsigned i = 0; i < n_done; i++) begin
      part = (i == n_done - 1) ? total - (total / n_done) * (n_done - 1) : total / n_done;
      send_item(CMD_DONE, $urandom_range(63), part);
    end
    send_item(CMD_TICK, $urandom_range(63), $urandom_range(BYTES_MAX));
  endtask

  // mostly well-formed ticks, with the odd restart and fully random noise items
  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 3)
        send_item(CMD_START, $urandom_range(63), $urandom_range(BYTES_MAX));
      else if (roll < 12)
        send_item(cmd_t'($urandom_range(3)), $urandom_range(63), $urandom_range(BYTES_MAX));
      else
        tick_period();
    end
  endtask

  task automatic run_phase(input longint unsigned budget, input longint unsigned req,
                           input longint unsigned maxd, input bit restart,
                           input int unsigned n, input idle_t idle);
    settle();
    write_reg(REG_BUDGET, budget);
    write_reg(REG_REQ_BYTES, req);
    write_reg(REG_MAX_DEPTH, maxd);
    send_idle_pct = (idle == IDLE_SEND) ? 62 : (idle == IDLE_BOTH) ? 22 : 0;
    recv_stall_pct = (idle == IDLE_RECV) ? 62 : (idle == IDLE_BOTH) ? 22 : 0;
    seg_left = 0;
    if (restart) send_item(CMD_START, $urandom_range(63), $urandom_range(BYTES_MAX));
    random_traffic(n);
  endtask

  initial begin
    longint unsigned b;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before any start: depth is zero so everything parks; unlimited ticks still report
    send_item(CMD_ISSUE, 0, 0);
    send_item(CMD_ISSUE, 63, BYTES_MAX);
    send_item(CMD_DONE, 63, BYTES_MAX);
    send_item(CMD_DONE, 0, 0);
    send_item(CMD_TICK, 0, 0);
    // unlimited run: full depth, grants without a debit
    send_item(CMD_START, 0, 0);
    send_item(CMD_ISSUE, 7, 0);
    send_item(CMD_ISSUE, 8, 0);
    send_item(CMD_TICK, 0, 0);

    // throttled run: drain the bucket to a refusal, then refill up to the burst cap
    settle();
    write_reg(REG_BUDGET, 3 * 1048576);
    write_reg(REG_REQ_BYTES, 1048576);
    write_reg(REG_MAX_DEPTH, 8);
    send_item(CMD_START, 0, 0);
    send_item(CMD_ISSUE, 1, 0);
    send_item(CMD_ISSUE, 2, 0);
    send_item(CMD_ISSUE, 0, 0);
    send_item(CMD_ISSUE, 0, 0);
    send_item(CMD_ISSUE, 1, 0);
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_TICK, 0, 0);

    // single worker, then no workers at all
    settle();
    write_reg(REG_MAX_DEPTH, 1);
    send_item(CMD_START, 0, 0);
    send_item(CMD_ISSUE, 1, 0);
    settle();
    write_reg(REG_MAX_DEPTH, 0);
    send_item(CMD_START, 0, 0);
    send_item(CMD_ISSUE, 0, 0);

    // depth above the limit acts as the limit
    settle();
    write_reg(REG_BUDGET, 0);
    write_reg(REG_MAX_DEPTH, 127);
    send_item(CMD_START, 0, 0);
    send_item(CMD_ISSUE, 63, 0);

    // widest budget and request, then a budget cut mid-run pulls the bucket down
    settle();
    write_reg(REG_BUDGET, BUDGET_MAX);
    write_reg(REG_REQ_BYTES, BYTES_MAX);
    write_reg(REG_MAX_DEPTH, 64);
    send_item(CMD_START, 0, 0);
    send_item(CMD_ISSUE, 1, 0);
    send_item(CMD_TICK, 0, 0);
    settle();
    write_reg(REG_BUDGET, 4096);
    write_reg(REG_REQ_BYTES, 4096);
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_ISSUE, 0, 0);

    // a run of the largest completions closed by a tick, then one empty tick
    settle();
    write_reg(REG_BUDGET, 0);
    send_item(CMD_START, 0, 0);
    repeat (40) send_item(CMD_DONE, $urandom_range(63), BYTES_MAX);
    send_item(CMD_TICK, 0, 0);
    send_item(CMD_TICK, 0, 0);

    // random phases across settings and idling patterns
    b = $urandom_range(1 << 16, 1 << 22);
    run_phase(b, (b / 3 < 4096) ? 4096 : b / 3, 8, 1'b1, 220, IDLE_NONE);
    b = $urandom_range(1 << 16, 1 << 22);
    run_phase(b, (b / 4 < 4096) ? 4096 : b / 4, 64, 1'b1, 220, IDLE_SEND);
    // settings changed without a restart: depth keeps its value
    run_phase(sb.budget / 2, 4096, 3, 1'b0, 100, IDLE_RECV);
    run_phase(0, 1 << 28, $urandom_range(127), 1'b1, 100, IDLE_BOTH);
    run_phase(BUDGET_MAX, 1 << 28, 127, 1'b1, 100, IDLE_SEND);
    b = $urandom_range(1, 1 << 24);
    run_phase(b, $urandom_range(4096, 1 << 20), $urandom_range(1, 64), 1'b1, 100,
              IDLE_BOTH);

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && cfg_errors == 0 && sb.owed.size() == 0) begin
      $display("token_bucket_queue_depth_throttle: match");
    end else begin
      $display("token_bucket_queue_depth_throttle: mismatch");
    end
    $finish;
  end

endmodule

/* token_bucket_queue_depth_throttle.f */
+incdir+hw/rtl
hw/rtl/tbqdt_pkg.sv
hw/rtl/token_bucket_queue_depth_throttle.sv
hw/rtl/tbqdt_checker.sv
tb/sv/token_bucket_queue_depth_throttle_test.sv
